[rtl/core/tlr_pkg.sv]
// Shared types, widths and codes for the timeline ramp generator.
// Depends on nothing; every other file of the block uses it.

package tlr_pkg;

  // Fixed-point fraction bits shared by every format.
  localparam int FRAC_BITS  = 16;

  localparam int VALUE_W    = 32;
  localparam int DUR_W      = 31;
  localparam int DELTA_W    = 8 + FRAC_BITS;
  localparam int OPCODE_W   = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Step product, increment and new elapsed position.
  localparam int PROD_W     = DELTA_W + 1 + VALUE_W;
  localparam int INC_W      = PROD_W - FRAC_BITS;
  localparam int POS_W      = INC_W + 1;

  // Fraction (1.0 held exactly), blend difference and blend product.
  localparam int FRAC_W     = FRAC_BITS + 1;
  localparam int DIFF_W     = VALUE_W + 1;
  localparam int MIX_W      = DIFF_W + FRAC_W + 1;

  // Divider step counter.
  localparam int CNT_W      = $clog2(FRAC_BITS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK       = 3'd0,
    OP_PLAY       = 3'd1,
    OP_PLAY_START = 3'd2,
    OP_STOP       = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_PLAY_END   = 3'd5
  } opcode_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PAUSED   = 2'd0,
    MODE_PLAYING  = 2'd1,
    MODE_AT_START = 2'd2,
    MODE_AT_END   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START    = 2'd0,
    CFG_GOAL     = 2'd1,
    CFG_DURATION = 2'd2,
    CFG_SPEED    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_STEP,
    S_CLASS,
    S_DIV,
    S_MIX,
    S_HELD,
    S_OUT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic apply_cmd;
    logic mul;
    logic step;
    logic classify;
    logic div_step;
    logic mix;
    logic held;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tick_live;
    logic in_span;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/tlr_cmd_if.sv]
// Input channel of the timeline ramp generator: valid/ready plus one item.
// Depends on tlr_pkg for field widths.

interface tlr_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tlr_pkg::OPCODE_W-1:0]  opcode;
  logic [tlr_pkg::DELTA_W-1:0]   tick_delta;

  modport source (output valid, output opcode, output tick_delta, input ready);
  modport sink   (input valid, input opcode, input tick_delta, output ready);
endinterface

[rtl/core/tlr_res_if.sv]
// Result channel of the timeline ramp generator: valid/ready plus one result.
// Depends on tlr_pkg for field widths.

interface tlr_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [tlr_pkg::VALUE_W-1:0]  value;
  logic [tlr_pkg::MODE_W-1:0]          play_state;

  modport source (output valid, output value, output play_state, input ready);
  modport sink   (input valid, input value, input play_state, output ready);
endinterface

[rtl/core/tlr_ctrl.sv]
// Controller state machine of the timeline ramp generator.
// Depends on tlr_pkg; drives the datapath through dp_cmd_t.

module tlr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlr_pkg::dp_status_t status,
  output tlr_pkg::dp_cmd_t    cmd
);

  tlr_pkg::ctl_state_t           state;
  tlr_pkg::ctl_state_t           state_next;
  logic [tlr_pkg::CNT_W-1:0]     cnt;
  logic                          cnt_last;

  assign cnt_last = (cnt == tlr_pkg::CNT_W'(tlr_pkg::FRAC_BITS - 1));

  // State register and divider step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlr_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == tlr_pkg::S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tlr_pkg::S_IDLE: begin
        if (in_valid) state_next = tlr_pkg::S_EXEC;
      end
      tlr_pkg::S_EXEC: begin
        state_next = status.tick_live ? tlr_pkg::S_STEP : tlr_pkg::S_OUT;
      end
      tlr_pkg::S_STEP:  state_next = tlr_pkg::S_CLASS;
      tlr_pkg::S_CLASS: begin
        state_next = status.in_span ? tlr_pkg::S_DIV : tlr_pkg::S_MIX;
      end
      tlr_pkg::S_DIV: begin
        if (cnt_last) state_next = tlr_pkg::S_MIX;
      end
      tlr_pkg::S_MIX:  state_next = tlr_pkg::S_HELD;
      tlr_pkg::S_HELD: state_next = tlr_pkg::S_OUT;
      tlr_pkg::S_OUT: begin
        if (status.out_free) state_next = tlr_pkg::S_IDLE;
      end
      default: state_next = tlr_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      tlr_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      tlr_pkg::S_EXEC: begin
        cmd.mul       = status.tick_live;
        cmd.apply_cmd = !status.tick_live;
      end
      tlr_pkg::S_STEP:  cmd.step     = 1'b1;
      tlr_pkg::S_CLASS: cmd.classify = 1'b1;
      tlr_pkg::S_DIV:   cmd.div_step = 1'b1;
      tlr_pkg::S_MIX:   cmd.mix      = 1'b1;
      tlr_pkg::S_HELD:  cmd.held     = 1'b1;
      tlr_pkg::S_OUT:   cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/tlr_datapath.sv]
// Datapath of the timeline ramp generator: configuration, ramp state,
// step multiplier, fraction divider, blend multiplier and result register.
// Depends on tlr_pkg and tlr_res_if.

module tlr_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [tlr_pkg::OPCODE_W-1:0]        opcode,
  input  logic [tlr_pkg::DELTA_W-1:0]         tick_delta,
  input  tlr_pkg::dp_cmd_t                    cmd,
  output tlr_pkg::dp_status_t                 status,
  tlr_res_if.source                           res
);

  // Configuration registers.
  logic signed [tlr_pkg::VALUE_W-1:0]  start_value;
  logic signed [tlr_pkg::VALUE_W-1:0]  goal_value;
  logic [tlr_pkg::DUR_W-1:0]           duration;
  logic signed [tlr_pkg::VALUE_W-1:0]  play_speed;

  // Ramp state.
  logic signed [tlr_pkg::VALUE_W-1:0]  elapsed;
  logic                                backward;
  tlr_pkg::mode_t                      mode;
  logic signed [tlr_pkg::VALUE_W-1:0]  held_value;

  // Working registers.
  logic [tlr_pkg::OPCODE_W-1:0]        op_reg;
  logic [tlr_pkg::DELTA_W-1:0]         delta_reg;
  logic signed [tlr_pkg::PROD_W-1:0]   prod;
  logic signed [tlr_pkg::POS_W-1:0]    pos;
  logic [tlr_pkg::DUR_W-1:0]           rem;
  logic [tlr_pkg::FRAC_W-1:0]          frac;
  logic signed [tlr_pkg::MIX_W-1:0]    mixp;

  // Combinational helpers.
  logic signed [tlr_pkg::PROD_W-1:0]   prod_shift;
  logic signed [tlr_pkg::INC_W-1:0]    inc;
  logic signed [tlr_pkg::POS_W-1:0]    inc_ext;
  logic signed [tlr_pkg::POS_W-1:0]    pos_sum;
  logic signed [tlr_pkg::POS_W-1:0]    dur_ext;
  logic                                hit_start;
  logic                                hit_end;
  logic [tlr_pkg::DUR_W:0]             rem_shift;
  logic                                rem_ge;
  logic signed [tlr_pkg::DIFF_W-1:0]   diff;
  logic signed [tlr_pkg::MIX_W-1:0]    mix_shift;

  // Step increment: floor(delta * speed / 2^F), negated when running backward.
  assign prod_shift = prod >>> tlr_pkg::FRAC_BITS;
  assign inc        = signed'(prod_shift[tlr_pkg::INC_W-1:0]);
  assign inc_ext    = tlr_pkg::POS_W'(inc);
  assign pos_sum    = tlr_pkg::POS_W'(elapsed) + (backward ? -inc_ext : inc_ext);

  // End checks on the new position; reaching the start wins.
  assign dur_ext   = signed'({{(tlr_pkg::POS_W - tlr_pkg::DUR_W){1'b0}}, duration});
  assign hit_start = (pos <= signed'(tlr_pkg::POS_W'(0)));
  assign hit_end   = !hit_start && (pos >= dur_ext);

  // One restoring division step; the remainder always stays below duration.
  assign rem_shift = {rem, 1'b0};
  assign rem_ge    = (rem_shift >= {1'b0, duration});

  // Blend: start + floor((goal - start) * f / 2^F).
  assign diff      = tlr_pkg::DIFF_W'(goal_value) - tlr_pkg::DIFF_W'(start_value);
  assign mix_shift = mixp >>> tlr_pkg::FRAC_BITS;

  assign status.tick_live = (tlr_pkg::opcode_t'(op_reg) == tlr_pkg::OP_TICK)
                            && (mode == tlr_pkg::MODE_PLAYING);
  assign status.in_span   = !hit_start && !hit_end;
  assign status.out_free  = !res.valid || res.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= '0;
      goal_value  <= '0;
      duration    <= tlr_pkg::DUR_W'(1 << tlr_pkg::FRAC_BITS);
      play_speed  <= tlr_pkg::VALUE_W'(1 << tlr_pkg::FRAC_BITS);
    end else if (cfg_we) begin
      case (tlr_pkg::cfg_reg_t'(cfg_index))
        tlr_pkg::CFG_START:    start_value <= signed'(cfg_data[tlr_pkg::VALUE_W-1:0]);
        tlr_pkg::CFG_GOAL:     goal_value  <= signed'(cfg_data[tlr_pkg::VALUE_W-1:0]);
        tlr_pkg::CFG_DURATION: duration    <= cfg_data[tlr_pkg::DUR_W-1:0];
        tlr_pkg::CFG_SPEED:    play_speed  <= signed'(cfg_data[tlr_pkg::VALUE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Ramp state: commands, end pinning and the held value.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed    <= '0;
      backward   <= 1'b0;
      mode       <= tlr_pkg::MODE_PAUSED;
      held_value <= '0;
    end else begin
      if (cmd.apply_cmd) begin
        case (tlr_pkg::opcode_t'(op_reg))
          tlr_pkg::OP_PLAY: begin
            mode     <= tlr_pkg::MODE_PLAYING;
            backward <= 1'b0;
          end
          tlr_pkg::OP_PLAY_START: begin
            mode     <= tlr_pkg::MODE_PLAYING;
            backward <= 1'b0;
            elapsed  <= '0;
          end
          tlr_pkg::OP_STOP:    mode     <= tlr_pkg::MODE_PAUSED;
          tlr_pkg::OP_REVERSE: backward <= 1'b1;
          tlr_pkg::OP_PLAY_END: begin
            mode     <= tlr_pkg::MODE_PLAYING;
            backward <= 1'b1;
            elapsed  <= signed'({1'b0, duration});
          end
          default: ;
        endcase
      end
      if (cmd.classify) begin
        if (hit_start) begin
          elapsed <= '0;
          mode    <= tlr_pkg::MODE_AT_START;
        end else if (hit_end) begin
          elapsed <= signed'({1'b0, duration});
          mode    <= tlr_pkg::MODE_AT_END;
        end else begin
          elapsed <= signed'(pos[tlr_pkg::VALUE_W-1:0]);
        end
      end
      if (cmd.held) begin
        held_value <= start_value + signed'(mix_shift[tlr_pkg::VALUE_W-1:0]);
      end
    end
  end

  // Item capture, step product, position, divider and blend product.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_reg    <= opcode;
      delta_reg <= tick_delta;
    end
    if (cmd.mul) begin
      prod <= signed'({1'b0, delta_reg}) * play_speed;
    end
    if (cmd.step) begin
      pos <= pos_sum;
    end
    if (cmd.classify) begin
      rem <= pos[tlr_pkg::DUR_W-1:0];
      if (hit_end) begin
        frac <= tlr_pkg::FRAC_W'(1 << tlr_pkg::FRAC_BITS);
      end else begin
        frac <= '0;
      end
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= tlr_pkg::DUR_W'(rem_shift - {1'b0, duration});
      end else begin
        rem <= rem_shift[tlr_pkg::DUR_W-1:0];
      end
      frac <= {frac[tlr_pkg::FRAC_W-2:0], rem_ge};
    end
    if (cmd.mix) begin
      mixp <= diff * signed'({1'b0, frac});
    end
  end

  // Result register; valid holds until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (cmd.load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res.value      <= held_value;
      res.play_state <= mode;
    end
  end

endmodule

[rtl/core/timeline_lerp_ramp_top.sv]
// Top level of the timeline ramp generator: controller plus datapath.
// Depends on tlr_pkg, tlr_cmd_if, tlr_res_if, tlr_ctrl and tlr_datapath.

// The block handles one item at a time and returns one result per item.
// A command (play, play from start, stop, reverse, play from end, or a tick
// while not playing) passes the execute and output states before the next
// input transfer. A tick while playing passes execute, step, classify,
// divide, mix, held and output when the position stays inside the timeline,
// the restoring divider forming one fraction bit per cycle, and skips divide
// when it reaches either end. A new item is accepted while the previous
// result still waits in the output register; the block stalls only when it
// must load a new result into a still-full output register. Configuration
// writes take effect at once and must be made while no item is in progress.

module timeline_lerp_ramp_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlr_pkg::CFG_DATA_W-1:0]    cfg_data,
  tlr_cmd_if.sink                           cmd,
  tlr_res_if.source                         res
);

  tlr_pkg::dp_cmd_t     dp_cmd;
  tlr_pkg::dp_status_t  dp_status;
  logic                 in_ready;

  assign cmd.ready = in_ready;

  // Sequencer.
  tlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // Arithmetic and state.
  tlr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .opcode     (cmd.opcode),
    .tick_delta (cmd.tick_delta),
    .cmd        (dp_cmd),
    .status     (dp_status),
    .res        (res)
  );

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the timeline ramp generator: ticks and commands go in,
// each result is checked against a local predictor of value and play state.
// Depends on tlr_pkg, tlr_cmd_if, tlr_res_if and timeline_lerp_ramp_top.

module tb;
  import tlr_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 11;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 2 * (FRAC_BITS + 7);
  localparam int MAX_REPORTS  = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 130;

  // Opcodes that the block ignores.
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [DELTA_W-1:0]  delta;
    bit                  wait_drain;
  } ramp_item_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    mode_t                     state;
  } ramp_out_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  tlr_cmd_if cmd_ch ();
  tlr_res_if res_ch ();

  timeline_lerp_ramp_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // Predictor copy of the registers and of the ramp state.
  logic signed [VALUE_W-1:0] ramp_start;
  logic signed [VALUE_W-1:0] ramp_goal;
  logic signed [VALUE_W-1:0] ramp_speed;
  logic [DUR_W-1:0]          ramp_duration;
  logic signed [VALUE_W-1:0] ramp_elapsed;
  logic signed [VALUE_W-1:0] ramp_held;
  logic                      ramp_backward;
  mode_t                     ramp_mode;

  ramp_item_t pending_items[$];
  ramp_out_t  expected_outputs[$];

  int fail_count     = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int src_gap_pct    = 0;
  int sink_stall_pct = 0;
  int gap_left       = 0;
  int stall_left     = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Advance the timeline by one tick and blend the new held value.
  function automatic void ramp_tick(logic [DELTA_W-1:0] delta);
    longint one;
    longint inc;
    longint pos;
    longint frac;
    longint mix;
    one = longint'(1) << FRAC_BITS;
    inc = (longint'(delta) * longint'(ramp_speed)) >>> FRAC_BITS;
    if (ramp_backward) inc = -inc;
    pos = longint'(ramp_elapsed) + inc;
    if (pos <= 0) begin
      ramp_elapsed = '0;
      ramp_mode    = MODE_AT_START;
      frac         = 0;
    end else if (pos >= longint'(ramp_duration)) begin
      ramp_elapsed = VALUE_W'(ramp_duration);
      ramp_mode    = MODE_AT_END;
      frac         = one;
    end else begin
      ramp_elapsed = VALUE_W'(pos);
      frac         = (pos << FRAC_BITS) / longint'(ramp_duration);
    end
    mix = longint'(ramp_start) * (one - frac) + longint'(ramp_goal) * frac;
    ramp_held = VALUE_W'(mix >>> FRAC_BITS);
  endfunction

  // Apply one accepted item and return the result it must produce.
  function automatic ramp_out_t predict_ramp_step(logic [OPCODE_W-1:0] op,
                                                  logic [DELTA_W-1:0] delta);
    ramp_out_t r;
    case (op)
      OP_TICK: begin
        if (ramp_mode == MODE_PLAYING) ramp_tick(delta);
      end
      OP_PLAY: begin
        ramp_mode     = MODE_PLAYING;
        ramp_backward = 1'b0;
      end
      OP_PLAY_START: begin
        ramp_mode     = MODE_PLAYING;
        ramp_backward = 1'b0;
        ramp_elapsed  = '0;
      end
      OP_STOP: begin
        ramp_mode = MODE_PAUSED;
      end
      OP_REVERSE: begin
        ramp_backward = 1'b1;
      end
      OP_PLAY_END: begin
        ramp_mode     = MODE_PLAYING;
        ramp_backward = 1'b1;
        ramp_elapsed  = VALUE_W'(ramp_duration);
      end
      default: ;
    endcase
    r.value = ramp_held;
    r.state = ramp_mode;
    return r;
  endfunction

  function automatic int gap_length();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_START:    ramp_start    = data;
      CFG_GOAL:     ramp_goal     = data;
      CFG_DURATION: ramp_duration = data[DUR_W-1:0];
      CFG_SPEED:    ramp_speed    = data;
      default: ;
    endcase
  endtask

  task automatic set_ramp(logic [CFG_DATA_W-1:0] start_v, logic [CFG_DATA_W-1:0] goal_v,
                          logic [CFG_DATA_W-1:0] dur_v, logic [CFG_DATA_W-1:0] speed_v);
    write_reg(CFG_START, start_v);
    write_reg(CFG_GOAL, goal_v);
    write_reg(CFG_DURATION, dur_v);
    write_reg(CFG_SPEED, speed_v);
  endtask

  task automatic push_item(logic [OPCODE_W-1:0] op, logic [DELTA_W-1:0] delta,
                           bit drain = 1'b0);
    ramp_item_t it;
    it.opcode     = op;
    it.delta      = delta;
    it.wait_drain = drain;
    pending_items.push_back(it);
  endtask

  // Sampled away from the rising edge so that all updates of that edge have landed.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || cmd_ch.valid || expected_outputs.size() != 0);
  endtask

  // Mostly commands followed by runs of ticks, with stops and unused opcodes as noise.
  task automatic queue_ramp_traffic(int n_items, longint cap);
    ramp_item_t it;
    int counted;
    int pick;
    int run;
    counted = 0;
    while (counted < n_items) begin
      pick          = $urandom_range(0, 99);
      it.delta      = DELTA_W'($urandom);
      it.wait_drain = ($urandom_range(0, 99) < 2);
      run           = $urandom_range(1, 8);
      if (pick < 22) it.opcode = OP_PLAY_START;
      else if (pick < 38) it.opcode = OP_PLAY_END;
      else if (pick < 52) it.opcode = OP_PLAY;
      else if (pick < 64) it.opcode = OP_REVERSE;
      else if (pick < 74) begin
        it.opcode = OP_STOP;
        run       = $urandom_range(0, 1);
      end else if (pick < 80) begin
        it.opcode = OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        run       = 0;
      end else begin
        it.opcode = OP_TICK;
      end
      pending_items.push_back(it);
      if (pick < 74 || pick >= 80) counted++;
      repeat (run) begin
        it.opcode     = OP_TICK;
        it.wait_drain = 1'b0;
        it.delta      = ($urandom_range(0, 9) == 0) ? DELTA_W'($urandom)
                                                    : DELTA_W'($urandom_range(0, 32'(cap)));
        pending_items.push_back(it);
        if (pick < 64 || pick >= 80) counted++;
      end
    end
  endtask

  // Input side: offer queued items, predict each one at its transfer.
  always @(posedge clk) begin : drive_items
    logic       offer;
    ramp_item_t next_item;
    if (rst) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.opcode     <= OP_TICK;
      cmd_ch.tick_delta <= '0;
      gap_left      = 0;
      ramp_elapsed  = '0;
      ramp_held     = '0;
      ramp_backward = 1'b0;
      ramp_mode     = MODE_PAUSED;
    end else begin
      offer = cmd_ch.valid;
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_outputs.push_back(predict_ramp_step(cmd_ch.opcode, cmd_ch.tick_delta));
        offer    = 1'b0;
        gap_left = ($urandom_range(0, 99) < src_gap_pct) ? gap_length() : 0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].wait_drain || expected_outputs.size() == 0)) begin
          next_item = pending_items.pop_front();
          cmd_ch.opcode     <= next_item.opcode;
          cmd_ch.tick_delta <= next_item.delta;
          offer = 1'b1;
        end
      end
      cmd_ch.valid <= offer;
    end
  end

  // Result side: check each transfer against the oldest expectation, stall at random.
  always @(posedge clk) begin : check_results
    ramp_out_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h state %0d",
                                    res_ch.value, res_ch.play_state));
        end else begin
          want = expected_outputs.pop_front();
          if (res_ch.value !== want.value)
            report_mismatch($sformatf("value got %h want %h", res_ch.value, want.value));
          if (res_ch.play_state !== want.state)
            report_mismatch($sformatf("play_state got %0d want %s",
                                      res_ch.play_state, want.state.name()));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < sink_stall_pct) stall_left = gap_length();
      end
    end
  end

  // A run that stops making transfers has hung.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : run_test
    logic [CFG_DATA_W-1:0] start_v;
    logic [CFG_DATA_W-1:0] goal_v;
    logic [CFG_DATA_W-1:0] dur_v;
    logic [CFG_DATA_W-1:0] speed_v;
    longint                step_target;
    longint                speed_mag;
    longint                cap;

    ramp_start    = '0;
    ramp_goal     = '0;
    ramp_duration = DUR_W'(32'h0001_0000);
    ramp_speed    = 32'h0001_0000;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Full-range blend over four time units: every command, both ends, deltas at extremes.
    set_ramp(32'h8000_0000, 32'h7FFF_FFFF, 32'h0004_0000, 32'h0001_0000);
    push_item(OP_TICK, 24'hFF_FFFF);
    push_item(OP_SPARE_LO, 24'hAB_CDEF);
    push_item(OP_PLAY, 24'h0);
    push_item(OP_TICK, 24'h01_0000);
    push_item(OP_STOP, 24'h0);
    push_item(OP_TICK, 24'h02_0000);
    push_item(OP_PLAY_START, 24'h0);
    push_item(OP_TICK, 24'h0);
    push_item(OP_PLAY, 24'h0);
    push_item(OP_TICK, 24'h02_8000);
    push_item(OP_REVERSE, 24'h0);
    push_item(OP_TICK, 24'h00_8000);
    push_item(OP_TICK, 24'hFF_FFFF);
    push_item(OP_PLAY_END, 24'h0);
    push_item(OP_TICK, 24'h0);
    push_item(OP_PLAY_END, 24'h0);
    push_item(OP_TICK, 24'h00_0100);
    push_item(OP_PLAY, 24'h0, 1'b1);
    push_item(OP_TICK, 24'hFF_FFFF);
    wait_idle();

    // Longest timeline at the slowest speed: the fraction rounds to zero while playing.
    set_ramp(32'h1234_5678, 32'hF543_2110, 32'h7FFF_FFFF, 32'h0000_0001);
    push_item(OP_PLAY_START, 24'h0);
    push_item(OP_TICK, 24'h01_0000);
    push_item(OP_TICK, 24'hFF_FFFF);
    wait_idle();

    // Shortest timeline at the most negative speed, forward and backward.
    set_ramp(32'h0000_0000, 32'h0001_0000, 32'h0000_0001, 32'h8000_0000);
    push_item(OP_PLAY_START, 24'h0);
    push_item(OP_TICK, 24'h00_0001);
    push_item(OP_PLAY_END, 24'h0);
    push_item(OP_TICK, 24'h00_0001);
    wait_idle();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      start_v = pick_level();
      goal_v  = pick_level();
      case ($urandom_range(0, 5))
        0:       dur_v = 32'h1;
        1:       dur_v = 32'h7FFF_FFFF;
        2:       dur_v = $urandom_range(2, 32'hFFFF);
        3:       dur_v = $urandom_range(32'h1_0000, 32'h10_0000);
        default: dur_v = ($urandom & 32'h7FFF_FFFF) | 32'h1;
      endcase
      case ($urandom_range(0, 6))
        0: speed_v = 32'h0001_0000;
        1: speed_v = 32'hFFFF_0000;
        2: speed_v = 32'h0;
        3: speed_v = 32'h7FFF_FFFF;
        4: speed_v = 32'h8000_0000;
        5: begin
          speed_v = $urandom_range(1, 32'h4_0000);
          if ($urandom_range(0, 1) == 1) speed_v = -speed_v;
        end
        default: speed_v = $urandom;
      endcase
      // Make sure both ends of duration and speed are visited.
      if (ph == 3) dur_v = 32'h7FFF_FFFF;
      if (ph == 4) dur_v = 32'h1;
      if (ph == 5) speed_v = 32'h7FFF_FFFF;
      if (ph == 6) speed_v = 32'h8000_0000;
      set_ramp(start_v, goal_v, dur_v, speed_v);

      // Size tick deltas so that a ramp takes several ticks to cross the timeline.
      step_target = longint'(dur_v) / 6 + 1;
      speed_mag   = longint'($signed(speed_v));
      if (speed_mag < 0) speed_mag = -speed_mag;
      cap = (speed_mag == 0) ? longint'(24'hFF_FFFF) : (step_target << FRAC_BITS) / speed_mag;
      if (cap < 1) cap = 1;
      if (cap > longint'(24'hFF_FFFF)) cap = longint'(24'hFF_FFFF);

      src_gap_pct    = $urandom_range(0, 40);
      sink_stall_pct = $urandom_range(0, 40);
      if (ph == 1) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      // The result side holds off for a long stretch while items keep coming.
      if (ph == 2) begin
        src_gap_pct = 0;
        hold_requests++;
      end
      queue_ramp_traffic(PHASE_ITEMS, cap);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
